FILE: rtl/mrsp_pkg.sv
// ----------------------------------------------------------------------------
// mrsp_pkg: shared types and constants
// Status codes, event kinds, per-port parser state and result records.
// ----------------------------------------------------------------------------
package mrsp_pkg;

	localparam int PORTS     = 16;
	localparam int RES_DEPTH = 4;

	localparam logic [7:0] ST_NONE      = 8'h00;
	localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
	localparam logic [7:0] ST_NOTE_ON   = 8'h90;
	localparam logic [7:0] ST_POLY      = 8'hA0;
	localparam logic [7:0] ST_CONTROL   = 8'hB0;
	localparam logic [7:0] ST_PROGRAM   = 8'hC0;
	localparam logic [7:0] ST_AFTER     = 8'hD0;
	localparam logic [7:0] ST_BEND      = 8'hE0;
	localparam logic [7:0] ST_SYSEX     = 8'hF0;
	localparam logic [7:0] ST_UNDEF_F4  = 8'hF4;
	localparam logic [7:0] ST_UNDEF_F5  = 8'hF5;
	localparam logic [7:0] ST_TUNE_REQ  = 8'hF6;
	localparam logic [7:0] ST_EOX       = 8'hF7;
	localparam logic [7:0] ST_REALTIME  = 8'hF8;
	localparam logic [7:0] STATUS_BIT   = 8'h80;
	localparam logic [7:0] CMD_MASK     = 8'hF0;

	typedef enum logic [3:0] {
		KIND_REALTIME = 4'd0,
		KIND_RAW      = 4'd1,
		KIND_NOTE     = 4'd2,
		KIND_POLY     = 4'd3,
		KIND_CONTROL  = 4'd4,
		KIND_PROGRAM  = 4'd5,
		KIND_AFTER    = 4'd6,
		KIND_BEND     = 4'd7,
		KIND_SYSEX    = 4'd8
	} kind_t;

	typedef struct packed {
		logic [7:0] running_status;
		logic       have_first_data;
		logic [6:0] held_first_data;
	} port_state_t;

	typedef struct packed {
		logic [3:0]  port_out;
		kind_t       kind;
		logic [3:0]  channel;
		logic [6:0]  first_data;
		logic [13:0] value;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0]  count;     // number of results, 0..2
		result_t     res0;
		result_t     res1;
		logic        write;     // update the port state
		port_state_t next_state;
	} decode_t;

endpackage

FILE: rtl/midi_running_status_parser.sv
// ----------------------------------------------------------------------------
// midi_running_status_parser: per-port MIDI parser with running status
// A taken byte is registered in s1 and queued once there is room. Throughput: one byte per
// cycle while the queue has room for two results; output drains one result per cycle while
// out_ready is high, so two-result bytes hold the input. Reset clears valid, state and pointers.
// ----------------------------------------------------------------------------
module midi_running_status_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  port,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  port_out,
	output logic [3:0]  kind,
	output logic [3:0]  channel,
	output logic [6:0]  first_data,
	output logic [13:0] value,
	output logic        last
);
	import mrsp_pkg::*;

	logic        valid_s1;
	logic [3:0]  port_s1;
	logic [7:0]  byte_s1;

	port_state_t state_q [PORTS];
	port_state_t cur;
	decode_t     dec;
	logic        room;
	logic        advance;
	logic [1:0]  push_count;
	result_t     head;

	assign advance    = valid_s1 && room;
	assign in_ready   = !valid_s1 || room;
	assign push_count = advance ? dec.count : 2'd0;
	assign cur        = state_q[port_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			port_s1 <= port;
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PORTS; i++) begin
				state_q[i] <= '0;
			end
		end else if (advance && dec.write) begin
			state_q[port_s1] <= dec.next_state;
		end
	end

	mrsp_decode u_decode (
		.port      (port_s1),
		.data_byte (byte_s1),
		.cur       (cur),
		.dec       (dec)
	);

	mrsp_result_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (push_count),
		.push0      (dec.res0),
		.push1      (dec.res1),
		.room       (room),
		.head_valid (out_valid),
		.pop        (out_ready),
		.head       (head)
	);

	assign port_out   = head.port_out;
	assign kind       = head.kind;
	assign channel    = head.channel;
	assign first_data = head.first_data;
	assign value      = head.value;
	assign last       = head.last;

`ifndef SYNTH
	// the second result of a byte is queued together with the first
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("second result of a byte missing");

	a_realtime_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_REALTIME |-> last)
		else $error("realtime result not marked last");

	a_no_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_RAW || kind == KIND_REALTIME || kind == KIND_SYSEX)
		|-> channel == 4'd0 && first_data == 7'd0)
		else $error("channel or first data on a non-channel result");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && !room)
		else $error("input stalled without a held request");
`endif

endmodule

FILE: rtl/mrsp_decode.sv
// ----------------------------------------------------------------------------
// mrsp_decode: one-byte decode against a port's parser state
// Produces up to two results and the port's next state.
// ----------------------------------------------------------------------------
module mrsp_decode (
	input  logic [3:0]           port,
	input  logic [7:0]           data_byte,
	input  mrsp_pkg::port_state_t cur,
	output mrsp_pkg::decode_t    dec
);
	import mrsp_pkg::*;

	logic [7:0]  cmd;
	logic [3:0]  chan;
	logic [13:0] byte_val;
	result_t     raw;
	result_t     ev;

	always_comb begin
		cmd      = (cur.running_status >= ST_SYSEX) ? cur.running_status
		           : (cur.running_status & CMD_MASK);
		chan     = cur.running_status[3:0];
		byte_val = {6'd0, data_byte};

		raw            = '0;
		raw.port_out   = port;
		raw.kind       = KIND_RAW;
		raw.value      = byte_val;
		raw.last       = 1'b1;

		ev             = '0;
		ev.port_out    = port;
		ev.kind        = KIND_SYSEX;
		ev.value       = byte_val;
		ev.last        = 1'b1;

		dec            = '0;
		dec.next_state = cur;
		dec.res0       = raw;
		dec.res1       = ev;

		priority if (int'(port) >= PORTS) begin
			dec.count = 2'd0;
		end else if (data_byte >= ST_REALTIME) begin
			dec.count     = 2'd1;
			dec.res0.kind = KIND_REALTIME;
		end else if ((data_byte & STATUS_BIT) != '0) begin
			dec.write                      = 1'b1;
			dec.next_state.have_first_data = 1'b0;
			dec.count                      = 2'd1;
			priority if (data_byte == ST_TUNE_REQ || data_byte == ST_UNDEF_F4 ||
			             data_byte == ST_UNDEF_F5) begin
				dec.next_state.running_status = ST_NONE;
			end else if (data_byte == ST_SYSEX || data_byte == ST_EOX) begin
				dec.next_state.running_status = (data_byte == ST_SYSEX) ? ST_SYSEX : ST_NONE;
				dec.count                     = 2'd2;
				dec.res0.last                 = 1'b0;
			end else begin
				dec.next_state.running_status = data_byte;
			end
		end else begin
			dec.count = 2'd1;
			priority if (cmd == ST_NOTE_OFF || cmd == ST_NOTE_ON || cmd == ST_POLY ||
			             cmd == ST_CONTROL || cmd == ST_BEND) begin
				dec.write = 1'b1;
				if (cur.have_first_data) begin
					dec.next_state.have_first_data = 1'b0;
					dec.count                      = 2'd2;
					dec.res0.last                  = 1'b0;
					dec.res1.channel               = chan;
					dec.res1.first_data            = cur.held_first_data;
					priority if (cmd == ST_BEND) begin
						dec.res1.kind       = KIND_BEND;
						dec.res1.first_data = '0;
						dec.res1.value      = {data_byte[6:0], cur.held_first_data};
					end else if (cmd == ST_NOTE_OFF) begin
						dec.res1.kind  = KIND_NOTE;
						dec.res1.value = '0;
					end else if (cmd == ST_NOTE_ON) begin
						dec.res1.kind = KIND_NOTE;
					end else if (cmd == ST_POLY) begin
						dec.res1.kind = KIND_POLY;
					end else begin
						dec.res1.kind = KIND_CONTROL;
					end
				end else begin
					dec.next_state.have_first_data = 1'b1;
					dec.next_state.held_first_data = data_byte[6:0];
				end
			end else if (cmd == ST_PROGRAM || cmd == ST_AFTER) begin
				dec.count        = 2'd2;
				dec.res0.last    = 1'b0;
				dec.res1.kind    = (cmd == ST_PROGRAM) ? KIND_PROGRAM : KIND_AFTER;
				dec.res1.channel = chan;
			end else if (cmd == ST_SYSEX) begin
				dec.count     = 2'd2;
				dec.res0.last = 1'b0;
			end else begin
				// no status or system common: echo only
				dec.count = 2'd1;
			end
		end
	end

endmodule

FILE: rtl/mrsp_result_fifo.sv
// ----------------------------------------------------------------------------
// mrsp_result_fifo: small result queue
// Takes up to two results per cycle, hands out one per cycle while pop is high.
// ----------------------------------------------------------------------------
module mrsp_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_count,
	input  mrsp_pkg::result_t push0,
	input  mrsp_pkg::result_t push1,
	output logic              room,
	output logic              head_valid,
	input  logic              pop,
	output mrsp_pkg::result_t head
);
	import mrsp_pkg::*;

	localparam int PW = $clog2(RES_DEPTH);
	localparam int CW = $clog2(RES_DEPTH + 1);

	result_t         mem_q [RES_DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   count_q;
	logic            do_pop;

	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_q];
	assign room       = (int'(count_q) <= RES_DEPTH - 2);
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PW'(push_count);
			rd_q    <= rd_q + PW'(do_pop);
			count_q <= count_q + CW'(push_count) - CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			mem_q[wr_q] <= push0;
		end
		if (push_count == 2'd2) begin
			mem_q[wr_q + PW'(1)] <= push1;
		end
	end

endmodule
